### rtl/core/cedv_pkg.sv
// Types, codes and exp tables shared by the cascaded exponential damper.
package cedv_pkg;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [39:0]        time_us;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               settled;
  } out_t;

  localparam logic [1:0] CMD_SET_VALUE = 2'd0;
  localparam logic [1:0] CMD_SET_DEST  = 2'd1;
  localparam logic [1:0] CMD_INIT      = 2'd2;
  localparam logic [1:0] CMD_TICK      = 2'd3;

  localparam logic REG_TAU   = 1'b0;
  localparam logic REG_ORDER = 1'b1;

  localparam logic [31:0] TAU_RESET   = 32'd300000;
  localparam logic [2:0]  ORDER_RESET = 3'd3;

  localparam logic [32:0] GAP_COMP_MAX = 33'd65;
  localparam logic [14:0] GAP_SQ_MAX   = 15'd4294;

  localparam int DIV_W = 56;

  // exp(-i/16) in Q16
  function automatic logic [16:0] frac_exp(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd61565;
      5'd2:    v = 17'd57835;
      5'd3:    v = 17'd54331;
      5'd4:    v = 17'd51039;
      5'd5:    v = 17'd47947;
      5'd6:    v = 17'd45042;
      5'd7:    v = 17'd42313;
      5'd8:    v = 17'd39750;
      5'd9:    v = 17'd37341;
      5'd10:   v = 17'd35079;
      5'd11:   v = 17'd32954;
      5'd12:   v = 17'd30957;
      5'd13:   v = 17'd29081;
      5'd14:   v = 17'd27319;
      5'd15:   v = 17'd25664;
      default: v = 17'd24109;
    endcase
    return v;
  endfunction

  // exp(-n) in Q16
  function automatic logic [16:0] int_exp(input logic [3:0] n);
    logic [16:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/cedv_div.sv
// Restoring divider, one quotient bit per cycle: (dt << 16) / tau.
module cedv_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [39:0]                    dt,
  input  logic [31:0]                    divisor,
  output logic                           done,
  output logic [cedv_pkg::DIV_W-1:0]     quot
);

  localparam int CW = $clog2(cedv_pkg::DIV_W);

  logic [31:0]               rem;
  logic [31:0]               dvs;
  logic [cedv_pkg::DIV_W-1:0] dq;
  logic [CW-1:0]             cnt;
  logic                      busy;
  logic [32:0]               trial;
  logic                      ge;

  assign trial = {rem, dq[cedv_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign quot  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= divisor;
        dq   <= {dt, 16'd0};
      end else if (busy) begin
        rem <= ge ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        dq  <= {dq[cedv_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(cedv_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/cascaded_exponential_damper_vec3.sv
// Cascaded exponential damper for a 3-D Q16.16 vector, top level.
//
// Input channel in_valid/in_stall/in_data carries timestamped events; the
// output channel out_valid/out_stall/out_data carries at most one damped
// vector per event. in_stall is high from the accepted transaction until its
// work is done; an event is processed by one sequencer around a shared
// 33x17 multiplier.
// Processing: the first event (not started) records its time and gives nothing.
// With tau nonzero the sequencer waits on the divider (S_DIV), forms alpha
// (S_EMUL, S_AMUL, S_ALPHA), runs S_MUL and S_WR for each stage component and
// ends in S_FIN; with tau zero it skips the divider and the alpha steps.
// The serial divider takes most of an event's processing time.
// A finished result sits in an output register; the block accepts the next
// event while it waits, but holds its own next result in the finish state
// until the register is free, so a stalled receiver never loses data.
// Reset (rst, synchronous) clears the stages, the target and the start time,
// and loads tau = 300000 us and order = 3.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 tau,
// 1 order); use it only while the block is idle, the block does not enforce this.
module cascaded_exponential_damper_vec3 #(
  parameter int MAX_STAGES = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cedv_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cedv_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_EMUL  = 3'd2;
  localparam logic [2:0] S_AMUL  = 3'd3;
  localparam logic [2:0] S_ALPHA = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]         state;
  logic [31:0]        tau;
  logic [2:0]         order;
  logic signed [31:0] stage_val [MAX_STAGES][3];
  logic signed [31:0] target [3];
  logic signed [31:0] prev [3];
  logic [39:0]        last_time;
  logic [39:0]        now;
  logic [SW-1:0]      s;
  logic [1:0]         c;
  logic [16:0]        alpha;
  logic [3:0]         rk;
  logic [11:0]        rt;
  logic [3:0]         rn;
  logic               big;
  logic [49:0]        prod;
  logic               settled_acc;
  logic               comp_ok;
  logic [14:0]        sq_sum;

  logic               accept;
  logic [39:0]        dt;
  logic               div_start;
  logic               div_done;
  logic [cedv_pkg::DIV_W-1:0] quot;
  logic [16:0]        fa;
  logic [16:0]        fb;
  logic [16:0]        e_val;
  logic [32:0]        ma;
  logic [16:0]        mb;
  logic signed [31:0] src;
  logic signed [31:0] cur;
  logic signed [32:0] d;
  logic [32:0]        mag;
  logic               active;
  logic [32:0]        q;
  logic signed [32:0] newv33;
  logic signed [31:0] newv;
  logic signed [32:0] gd;
  logic [32:0]        gm;
  logic [13:0]        sq;
  logic               gm_ok;
  logic [14:0]        sum_next;
  logic               ok_next;
  logic               check;
  logic               out_free;
  logic               last_elem;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign dt       = (in_data.time_us >= last_time) ? in_data.time_us - last_time : 40'd0;
  assign div_start = accept && (last_time != 40'd0) && (tau != 32'd0);
  assign out_free = !out_valid || !out_stall;

  cedv_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dt      (dt),
    .divisor (tau),
    .done    (div_done),
    .quot    (quot)
  );

  assign fa    = cedv_pkg::frac_exp({1'b0, rk});
  assign fb    = cedv_pkg::frac_exp({1'b0, rk} + 5'd1);
  assign e_val = fa - prod[28:12];

  assign src    = (s == '0) ? target[c] : prev[c];
  assign cur    = stage_val[s][c];
  assign d      = {cur[31], cur} - {src[31], src};
  assign mag    = d[32] ? 33'(-d) : 33'(d);
  assign active = ({1'b0, order} > 4'(s)) && (tau != 32'd0);
  assign q      = 33'((prod + 50'd32768) >> 16);
  assign newv33 = d[32] ? ({src[31], src} - $signed(q)) : ({src[31], src} + $signed(q));
  assign newv   = active ? newv33[31:0] : src;
  assign gd     = {newv[31], newv} - {src[31], src};
  assign gm     = gd[32] ? 33'(-gd) : 33'(gd);
  assign gm_ok  = gm <= cedv_pkg::GAP_COMP_MAX;
  assign sq     = {7'd0, gm[6:0]} * {7'd0, gm[6:0]};
  assign sum_next = ((c == 2'd0) ? 15'd0 : sq_sum) + {1'b0, sq};
  assign ok_next  = ((c == 2'd0) ? 1'b1 : comp_ok) && gm_ok;
  assign check    = (s == '0) || ({1'b0, order} > 4'(s));
  assign last_elem = (c == 2'd2) && (s == SW'(MAX_STAGES - 1));

  always_comb begin
    ma = mag;
    mb = alpha;
    unique case (state)
      S_EMUL: begin
        ma = 33'(fa - fb);
        mb = {5'd0, rt};
      end
      S_AMUL: begin
        ma = {16'd0, cedv_pkg::int_exp(rn)};
        mb = e_val;
      end
      default: begin
        ma = mag;
        mb = alpha;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tau <= cedv_pkg::TAU_RESET;
      order <= cedv_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cedv_pkg::REG_TAU:   tau <= cfg_data;
        cedv_pkg::REG_ORDER: order <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 50'(ma * mb);
    if (div_done) begin
      rk  <= quot[15:12];
      rt  <= quot[11:0];
      rn  <= quot[19:16];
      big <= (|quot[cedv_pkg::DIV_W-1:20]) || (quot[19:16] >= 4'd12);
    end
    if (state == S_ALPHA) begin
      alpha <= big ? 17'd0 : 17'((prod + 50'd32768) >> 16);
    end
    if (accept) begin
      now <= in_data.time_us;
    end
    if (state == S_WR) begin
      prev[c] <= newv;
      sq_sum  <= sum_next;
      comp_ok <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_time   <= '0;
      out_valid   <= 1'b0;
      s           <= '0;
      c           <= '0;
      settled_acc <= 1'b1;
      for (int i = 0; i < MAX_STAGES; i++) begin
        for (int j = 0; j < 3; j++) begin
          stage_val[i][j] <= '0;
        end
      end
      for (int j = 0; j < 3; j++) begin
        target[j] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.cmd == cedv_pkg::CMD_SET_VALUE) begin
              for (int i = 0; i < MAX_STAGES; i++) begin
                stage_val[i][0] <= in_data.vec_x;
                stage_val[i][1] <= in_data.vec_y;
                stage_val[i][2] <= in_data.vec_z;
              end
            end else if (in_data.cmd == cedv_pkg::CMD_SET_DEST) begin
              target[0] <= in_data.vec_x;
              target[1] <= in_data.vec_y;
              target[2] <= in_data.vec_z;
            end
            s <= '0;
            c <= '0;
            settled_acc <= 1'b1;
            if (last_time == 40'd0) begin
              last_time <= in_data.time_us;
            end else if (tau != 32'd0) begin
              state <= S_DIV;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMUL;
          end
        end
        S_EMUL:  state <= S_AMUL;
        S_AMUL:  state <= S_ALPHA;
        S_ALPHA: state <= S_MUL;
        S_MUL:   state <= S_WR;
        S_WR: begin
          stage_val[s][c] <= newv;
          if (c == 2'd2 && check &&
              !(ok_next && (sum_next <= cedv_pkg::GAP_SQ_MAX))) begin
            settled_acc <= 1'b0;
          end
          if (last_elem) begin
            state <= S_FIN;
          end else begin
            state <= S_MUL;
            if (c == 2'd2) begin
              c <= '0;
              s <= s + 1'b1;
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data.settled <= settled_acc;
            if (settled_acc) begin
              for (int i = 0; i < MAX_STAGES; i++) begin
                for (int j = 0; j < 3; j++) begin
                  stage_val[i][j] <= target[j];
                end
              end
              out_data.out_x <= target[0];
              out_data.out_y <= target[1];
              out_data.out_z <= target[2];
            end else begin
              out_data.out_x <= prev[0];
              out_data.out_y <= prev[1];
              out_data.out_z <= prev[2];
              last_time <= now;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside the finish step");

  a_settled_is_target: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_data.settled) |->
      (out_data.out_x == target[0] && out_data.out_y == target[1] &&
       out_data.out_z == target[2]))
    else $error("settled result differs from target");

endmodule

### test/tb.sv
// Self-checking testbench for the cascaded exponential damper (vec3).
module tb;

  localparam int unsigned FRAC_TBL[17] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
    42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664, 24109};
  localparam int unsigned EXPN_TBL[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
    22, 8, 3, 1};
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cedv_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cedv_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = cedv_pkg::REG_TAU;
  logic [31:0] cfg_data = '0;

  cascaded_exponential_damper_vec3 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // damper mirror
  longint stage_m[5][3];
  longint dest_m[3];
  logic [39:0] start_m;
  logic [31:0] tau_m;
  logic [2:0] order_m;

  cedv_pkg::in_t event_q[$];
  cedv_pkg::out_t damped_q[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  int errors = 0;
  int n_events = 0;
  int n_results = 0;
  int n_settled = 0;

  function automatic logic [63:0] decay_factor(logic [63:0] dt);
    logic [63:0] r, n, f, k, t, a, b, e;
    r = (dt << 16) / {32'd0, tau_m};
    n = r >> 16;
    if (n >= 12) return 64'd0;
    f = r & 64'hFFFF;
    k = f >> 12;
    t = f & 64'hFFF;
    a = FRAC_TBL[k];
    b = FRAC_TBL[k + 1];
    e = a - (((a - b) * t) >> 12);
    return (64'(EXPN_TBL[n]) * e + 64'd32768) >> 16;
  endfunction

  function automatic longint pull_toward(longint src, longint cur, logic [63:0] al);
    longint d;
    logic [63:0] m, q;
    d = cur - src;
    m = d < 0 ? 64'(-d) : 64'(d);
    q = (m * al + 64'd32768) >> 16;
    return d < 0 ? src - longint'(q) : src + longint'(q);
  endfunction

  // s0 < 0 compares stage s1 against the destination
  function automatic bit gap_below(int s1, int s0);
    longint d, b;
    logic [63:0] m, sum;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      b = s0 < 0 ? dest_m[c] : stage_m[s0][c];
      d = stage_m[s1][c] - b;
      m = d < 0 ? 64'(-d) : 64'(d);
      if (m > 65) return 0;
      sum += m * m;
    end
    return sum <= 64'd4294;
  endfunction

  function automatic bit damp_event(cedv_pkg::in_t ev, output cedv_pkg::out_t res);
    longint v[3];
    logic [63:0] dt, al;
    bit ok;
    res = '0;
    v[0] = $signed(ev.vec_x);
    v[1] = $signed(ev.vec_y);
    v[2] = $signed(ev.vec_z);
    if (ev.cmd == cedv_pkg::CMD_SET_VALUE) begin
      for (int s = 0; s < 5; s++)
        for (int c = 0; c < 3; c++) stage_m[s][c] = v[c];
    end else if (ev.cmd == cedv_pkg::CMD_SET_DEST) begin
      for (int c = 0; c < 3; c++) dest_m[c] = v[c];
    end
    if (start_m == 0) begin
      start_m = ev.time_us;
      return 0;
    end
    dt = ev.time_us >= start_m ? 64'(ev.time_us - start_m) : 64'd0;
    al = tau_m != 0 ? decay_factor(dt) : 64'd65536;
    for (int s = 0; s < 5; s++)
      for (int c = 0; c < 3; c++) begin
        longint src;
        src = s == 0 ? dest_m[c] : stage_m[s - 1][c];
        stage_m[s][c] = (int'(order_m) > s && tau_m != 0) ?
                        pull_toward(src, stage_m[s][c], al) : src;
      end
    ok = gap_below(0, -1);
    for (int s = 1; s < 5; s++)
      if (int'(order_m) > s && !gap_below(s, s - 1)) ok = 0;
    if (ok) begin
      for (int s = 0; s < 5; s++)
        for (int c = 0; c < 3; c++) stage_m[s][c] = dest_m[c];
      res = '{32'(dest_m[0]), 32'(dest_m[1]), 32'(dest_m[2]), 1'b1};
      return 1;
    end
    res = '{32'(stage_m[4][0]), 32'(stage_m[4][1]), 32'(stage_m[4][2]), 1'b0};
    start_m = ev.time_us;
    return 1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= event_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= 600;
      hold_done <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cedv_pkg::out_t want, got;
    if (rst) begin
      for (int s = 0; s < 5; s++)
        for (int c = 0; c < 3; c++) stage_m[s][c] = 0;
      for (int c = 0; c < 3; c++) dest_m[c] = 0;
      start_m = '0;
      tau_m = cedv_pkg::TAU_RESET;
      order_m = cedv_pkg::ORDER_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cedv_pkg::REG_TAU) tau_m = cfg_data;
        else order_m = cfg_data[2:0];
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        n_results++;
        if (got.settled) n_settled++;
        if (damped_q.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, got);
          errors++;
        end else begin
          want = damped_q.pop_front();
          if (got.out_x !== want.out_x) begin
            $display("%0t: out_x expected %h actual %h", $time, want.out_x, got.out_x);
            errors++;
          end
          if (got.out_y !== want.out_y) begin
            $display("%0t: out_y expected %h actual %h", $time, want.out_y, got.out_y);
            errors++;
          end
          if (got.out_z !== want.out_z) begin
            $display("%0t: out_z expected %h actual %h", $time, want.out_z, got.out_z);
            errors++;
          end
          if (got.settled !== want.settled) begin
            $display("%0t: settled expected %b actual %b", $time, want.settled, got.settled);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_events++;
        if (damp_event(in_data, want)) damped_q.push_back(want);
      end
    end
  end

  // stimulus side
  logic [39:0] now_g = '0;
  logic [31:0] tau_g = cedv_pkg::TAU_RESET;
  longint dest_g[3] = '{0, 0, 0};

  task automatic send(logic [1:0] cmd, logic [39:0] t, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z);
    event_q.push_back(cedv_pkg::in_t'{cmd, t, x, y, z});
    if (cmd == cedv_pkg::CMD_SET_DEST) begin
      dest_g[0] = $signed(x);
      dest_g[1] = $signed(y);
      dest_g[2] = $signed(z);
    end
  endtask

  task automatic cfg_write(logic idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cedv_pkg::REG_TAU) tau_g = v;
  endtask

  task automatic drain();
    while (event_q.size() > 0 || in_valid || damped_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] near_dest(int c);
    if ($urandom_range(7) == 0) return $urandom;
    return 32'(dest_g[c] + longint'($urandom_range(0, 400)) - 200);
  endfunction

  task automatic random_events(int n);
    logic [1:0] cmd;
    logic [63:0] dt;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      cmd = pick < 50 ? cedv_pkg::CMD_TICK : pick < 70 ? cedv_pkg::CMD_SET_DEST
          : pick < 85 ? cedv_pkg::CMD_SET_VALUE : cedv_pkg::CMD_INIT;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: dt = 64'(tau_g) * $urandom_range(0, 100) / 1600;
        5, 6, 7: dt = 64'(tau_g) * $urandom_range(0, 400) / 100;
        8: dt = 64'(tau_g) * 13 + $urandom_range(0, 1000);
        default: dt = {$urandom, $urandom} - 64'(now_g);
      endcase
      dt += $urandom_range(0, 3) == 0 ? $urandom_range(0, 50) : 0;
      now_g = now_g + 40'(dt);
      send(cmd, now_g, near_dest(0), near_dest(1), near_dest(2));
    end
  endtask

  task automatic phase(logic [31:0] tau, logic [2:0] ord, int sidle, int stall, int n);
    cfg_write(cedv_pkg::REG_TAU, tau);
    cfg_write(cedv_pkg::REG_ORDER, {29'd0, ord});
    send_idle_pct = sidle;
    stall_pct = stall;
    random_events(n);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed: not started at time zero, start, extremes, backwards time, settle
    send(cedv_pkg::CMD_TICK, 40'd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    send(cedv_pkg::CMD_SET_VALUE, 40'd0, 32'h00010000, 32'hFFFF0000, 32'h0);
    send(cedv_pkg::CMD_SET_VALUE, 40'd5, 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
    send(cedv_pkg::CMD_SET_DEST, 40'd1000, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send(cedv_pkg::CMD_TICK, 40'd30000, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_INIT, 40'd330000, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F);
    send(cedv_pkg::CMD_TICK, 40'd200, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_TICK, 40'd1500000, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_TICK, 40'd9000000, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_SET_DEST, 40'd9000001, 32'h00000040, 32'hFFFFFFC0, 32'h00000010);
    send(cedv_pkg::CMD_SET_VALUE, 40'd9000002, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_TICK, 40'd9100000, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_TICK, 40'hFFFFFFFFFF, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_SET_DEST, 40'hFFFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(cedv_pkg::CMD_SET_VALUE, 40'h5555555555, 32'h80000000, 32'h80000000,
         32'h80000000);
    send(cedv_pkg::CMD_TICK, 40'hAAAAAAAAAA, 32'h0, 32'h0, 32'h0);
    send(cedv_pkg::CMD_TICK, 40'hFFFFFFFFFF, 32'h0, 32'h0, 32'h0);
    now_g = 40'hFFFFFFFFFF;
    drain();
    phase(32'd300000, 3'd3, 0, 0, 150);
    phase(32'd0, 3'd5, 88, 0, 100);
    phase(32'hFFFFFFFF, 3'd0, 0, 88, 100);
    phase(32'd1000, 3'd7, 34, 34, 150);
    phase(32'd1, 3'd1, 0, 0, 120);
    cfg_write(cedv_pkg::REG_TAU, 32'd50000);
    cfg_write(cedv_pkg::REG_ORDER, 32'd5);
    send_idle_pct = 0;
    stall_pct = 0;
    random_events(120);
    @(negedge clk);
    hold_go = 1'b1;
    drain();
    phase(32'd2000000, 3'd6, 88, 88, 100);
    phase(32'd300000, 3'd2, 0, 0, 150);
    phase(32'd7, 3'd4, 34, 34, 140);
    $display("Covered %0d events, %0d results, %0d settled, tau 0..max, orders 0..7.",
             n_events, n_results, n_settled);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
